// ----- rtl/shape_pixel_coverage_assert.svh -----
// assertion macros used by the checker of the shape coverage block
`ifndef SHAPE_PIXEL_COVERAGE_ASSERT_SVH
`define SHAPE_PIXEL_COVERAGE_ASSERT_SVH

// same-cycle implication, off during reset
`define SPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define SPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// holds at every edge, reset included
`define SPC_ASSERT_ALWAYS(lbl, clk, cond, msg) \
	lbl: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ----- rtl/spc_pkg.sv -----
`default_nettype none

package spc_pkg;

	localparam int CANVAS_WIDTH_DEF  = 1024;
	localparam int CANVAS_HEIGHT_DEF = 1024;
	localparam int TRIG_FRAC_DEF     = 15;

	localparam int COORD_W    = 10;
	localparam int POS_W      = 12;
	localparam int SIZE_W     = 10;
	localparam int TILT_W     = 9;
	localparam int COLOR_W    = 24;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OFS_W      = POS_W + 1;
	localparam int SQ_W       = 2 * SIZE_W;
	localparam int RXRY_W     = 2 * SQ_W;
	localparam int ROT_FRAC   = 8;
	localparam int MAG_W      = POS_W + ROT_FRAC + 1;
	localparam int MAG2_W     = 2 * MAG_W;
	localparam int TERM_W     = MAG2_W + SQ_W;
	localparam int SUM_W      = TERM_W + 1;

	localparam logic [KIND_W-1:0] KIND_RECT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ELLIPSE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ROTATED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_DEG   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 3'd6;

	// pi in q30
	localparam longint PI_Q30 = 64'sd3373259426;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [POS_W-1:0]  shape_x;
		logic signed [POS_W-1:0]  shape_y;
		logic [SIZE_W-1:0]        size_x;
		logic [SIZE_W-1:0]        size_y;
		logic [SQ_W-1:0]          rx2;
		logic [SQ_W-1:0]          ry2;
		logic [RXRY_W-1:0]        rxry;
		logic [COLOR_W-1:0]       fill;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/spc_if.sv -----
`default_nettype none

interface spc_in_if;
	logic                         valid;
	logic                         ready;
	logic [spc_pkg::COORD_W-1:0]  pixel_x;
	logic [spc_pkg::COORD_W-1:0]  pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface spc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         covered;
	logic [spc_pkg::COLOR_W-1:0]  pixel_color;

	modport source (output valid, output covered, output pixel_color, input ready);
	modport sink   (input valid, input covered, input pixel_color, output ready);
endinterface

`default_nettype wire

// ----- rtl/shape_pixel_coverage.sv -----
// an accepted pixel beat passes through stages 1 to 6 to its result beat, stage 6 being the output register
// throughput: one pixel per cycle while the output is ready, set by the six-stage pipeline with no shared unit
// a stall at the output backs up stage by stage, bubbles are squeezed out
// reset: asynchronous, clears all stage valid bits and every shape register to zero
// (rectangle at the origin of size zero, tilt zero so cosine reads one)
`default_nettype none

module shape_pixel_coverage #(
	parameter int CANVAS_WIDTH       = spc_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT      = spc_pkg::CANVAS_HEIGHT_DEF,
	parameter int TRIG_FRACTION_BITS = spc_pkg::TRIG_FRAC_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	spc_in_if.sink                               pixel,
	spc_out_if.source                            result,
	input  wire logic                            wr_en,
	input  wire logic [spc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [spc_pkg::CFG_DATA_W-1:0]  wr_data
);

	localparam int TW     = TRIG_FRACTION_BITS + 2;
	localparam int PROD_W = spc_pkg::OFS_W + TW;
	localparam int ROT_W  = PROD_W + 1;
	// rotated offsets come out in q(trig) and their magnitudes are rounded half up to q8
	localparam int SH     = TRIG_FRACTION_BITS - spc_pkg::ROT_FRAC;
	localparam int RND    = (SH == 0) ? 0 : (1 << (SH - 1));
	localparam int CMP_W  = spc_pkg::OFS_W + 1;

	// shape registers and the rotation pair; the user must write them only while idle, the block does not enforce it
	spc_pkg::cfg_t        cfg;
	logic signed [TW-1:0] cos_val;
	logic signed [TW-1:0] sin_val;

	spc_cfg #(
		.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.cfg     (cfg),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	// per-stage advance: a stage loads when it is empty or its successor moves
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || result.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pixel.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixel.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: offsets from the shape origin and the canvas test
	logic signed [spc_pkg::OFS_W-1:0] ox_s1, oy_s1;
	logic                             inb_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ox_s1  <= $signed({3'b000, pixel.pixel_x}) - $signed({cfg.shape_x[spc_pkg::POS_W-1],
				cfg.shape_x});
			oy_s1  <= $signed({3'b000, pixel.pixel_y}) - $signed({cfg.shape_y[spc_pkg::POS_W-1],
				cfg.shape_y});
			inb_s1 <= (CMP_W'(pixel.pixel_x) < CMP_W'(CANVAS_WIDTH)) &&
				(CMP_W'(pixel.pixel_y) < CMP_W'(CANVAS_HEIGHT));
		end
	end

	// stage 2: rotation products, magnitudes, rectangle and reach tests
	logic [spc_pkg::POS_W-1:0]         ax_c, ay_c;
	logic [spc_pkg::POS_W-1:0]         reach;
	logic                              rect_hit, sizes_ok, reach_ok;
	logic signed [PROD_W-1:0]          p_xc_s2, p_ys_s2, p_xs_s2, p_yc_s2;
	logic [spc_pkg::POS_W-1:0]         ax_s2, ay_s2;
	logic                              rect_s2, ell_s2;

	always_comb begin
		ax_c     = ox_s1[spc_pkg::OFS_W-1] ? spc_pkg::POS_W'(-ox_s1) : spc_pkg::POS_W'(ox_s1);
		ay_c     = oy_s1[spc_pkg::OFS_W-1] ? spc_pkg::POS_W'(-oy_s1) : spc_pkg::POS_W'(oy_s1);
		reach    = spc_pkg::POS_W'(cfg.size_x) + spc_pkg::POS_W'(cfg.size_y) +
			spc_pkg::POS_W'(2);
		reach_ok = (ax_c <= reach) && (ay_c <= reach);
		sizes_ok = (cfg.size_x != '0) && (cfg.size_y != '0);
		rect_hit = !ox_s1[spc_pkg::OFS_W-1] && !oy_s1[spc_pkg::OFS_W-1] &&
			(ox_s1 < $signed({3'b000, cfg.size_x})) &&
			(oy_s1 < $signed({3'b000, cfg.size_y}));
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_xc_s2 <= ox_s1 * cos_val;
			p_ys_s2 <= oy_s1 * sin_val;
			p_xs_s2 <= ox_s1 * sin_val;
			p_yc_s2 <= oy_s1 * cos_val;
			ax_s2   <= ax_c;
			ay_s2   <= ay_c;
			rect_s2 <= inb_s1 && (cfg.kind == spc_pkg::KIND_RECT) && rect_hit;
			// zero radius draws nothing; the rotated form also drops far pixels
			ell_s2  <= inb_s1 && sizes_ok && ((cfg.kind == spc_pkg::KIND_ELLIPSE) ||
				((cfg.kind == spc_pkg::KIND_ROTATED) && reach_ok));
		end
	end

	// stage 3: rotated coordinates, rounded to q8 magnitudes
	logic signed [ROT_W-1:0]   u_sum, v_sum;
	logic [ROT_W-1:0]          u_mag, v_mag;
	logic [ROT_W-1:0]          u_rnd, v_rnd;
	logic [spc_pkg::MAG_W-1:0] a_c, b_c;
	logic [spc_pkg::MAG_W-1:0] a_s3, b_s3;
	logic                      rect_s3, ell_s3;

	always_comb begin
		u_sum = $signed({p_xc_s2[PROD_W-1], p_xc_s2}) + $signed({p_ys_s2[PROD_W-1], p_ys_s2});
		v_sum = $signed({p_yc_s2[PROD_W-1], p_yc_s2}) - $signed({p_xs_s2[PROD_W-1], p_xs_s2});
		u_mag = u_sum[ROT_W-1] ? ROT_W'(-u_sum) : ROT_W'(u_sum);
		v_mag = v_sum[ROT_W-1] ? ROT_W'(-v_sum) : ROT_W'(v_sum);
		u_rnd = (u_mag + ROT_W'(RND)) >> SH;
		v_rnd = (v_mag + ROT_W'(RND)) >> SH;
		// the axis ellipse goes through the same q8 datapath unrotated
		if (cfg.kind == spc_pkg::KIND_ROTATED) begin
			a_c = spc_pkg::MAG_W'(u_rnd);
			b_c = spc_pkg::MAG_W'(v_rnd);
		end else begin
			a_c = spc_pkg::MAG_W'({ax_s2, {spc_pkg::ROT_FRAC{1'b0}}});
			b_c = spc_pkg::MAG_W'({ay_s2, {spc_pkg::ROT_FRAC{1'b0}}});
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			a_s3    <= a_c;
			b_s3    <= b_c;
			rect_s3 <= rect_s2;
			ell_s3  <= ell_s2;
		end
	end

	// stage 4: squares of the q8 offsets
	logic [spc_pkg::MAG2_W-1:0] a2_s4, b2_s4;
	logic                       rect_s4, ell_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			a2_s4   <= spc_pkg::MAG2_W'(a_s3) * spc_pkg::MAG2_W'(a_s3);
			b2_s4   <= spc_pkg::MAG2_W'(b_s3) * spc_pkg::MAG2_W'(b_s3);
			rect_s4 <= rect_s3;
			ell_s4  <= ell_s3;
		end
	end

	// stage 5: cross-weight by the other radius squared
	logic [spc_pkg::TERM_W-1:0] ta_s5, tb_s5;
	logic                       rect_s5, ell_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			ta_s5   <= spc_pkg::TERM_W'(a2_s4) * spc_pkg::TERM_W'(cfg.ry2);
			tb_s5   <= spc_pkg::TERM_W'(b2_s4) * spc_pkg::TERM_W'(cfg.rx2);
			rect_s5 <= rect_s4;
			ell_s5  <= ell_s4;
		end
	end

	// stage 6: compare against rx^2*ry^2 in q16, output register
	logic [spc_pkg::SUM_W-1:0] lhs, rhs;
	logic                      cov_c;
	logic                      cov_s6;
	logic [spc_pkg::COLOR_W-1:0] color_s6;

	always_comb begin
		lhs   = spc_pkg::SUM_W'(ta_s5) + spc_pkg::SUM_W'(tb_s5);
		rhs   = spc_pkg::SUM_W'({cfg.rxry, {(2 * spc_pkg::ROT_FRAC){1'b0}}});
		cov_c = rect_s5 || (ell_s5 && (lhs <= rhs));
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			cov_s6   <= cov_c;
			color_s6 <= cov_c ? cfg.fill : '0;
		end
	end

	assign result.valid       = v_s6;
	assign result.covered     = cov_s6;
	assign result.pixel_color = color_s6;

endmodule

`default_nettype wire

// ----- rtl/spc_cfg.sv -----
`default_nettype none

module spc_cfg #(
	parameter int TRIG_FRACTION_BITS = spc_pkg::TRIG_FRAC_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [spc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [spc_pkg::CFG_DATA_W-1:0]    wr_data,
	output spc_pkg::cfg_t                          cfg,
	output logic signed [TRIG_FRACTION_BITS+1:0]   cos_val,
	output logic signed [TRIG_FRACTION_BITS+1:0]   sin_val
);

	localparam int TW  = TRIG_FRACTION_BITS + 2;
	localparam int TMW = TRIG_FRACTION_BITS + 1;

	logic [TMW-1:0] sin_tab [0:90];

	// whole-degree sine, taylor series in q30 folded at elaboration, rounded to q(frac)
	for (genvar g = 0; g <= 90; g++) begin : g_sin
		localparam longint TH   = (longint'(g) * spc_pkg::PI_Q30) / 180;
		localparam longint TH2  = (TH * TH) >>> 30;
		localparam longint T1   = ((TH * TH2) >>> 30) / 6;
		localparam longint T2   = ((T1 * TH2) >>> 30) / 20;
		localparam longint T3   = ((T2 * TH2) >>> 30) / 42;
		localparam longint T4   = ((T3 * TH2) >>> 30) / 72;
		localparam longint T5   = ((T4 * TH2) >>> 30) / 110;
		localparam longint T6   = ((T5 * TH2) >>> 30) / 156;
		localparam longint T7   = ((T6 * TH2) >>> 30) / 210;
		localparam longint T8   = ((T7 * TH2) >>> 30) / 272;
		localparam longint T9   = ((T8 * TH2) >>> 30) / 342;
		localparam longint T10  = ((T9 * TH2) >>> 30) / 420;
		localparam longint T11  = ((T10 * TH2) >>> 30) / 506;
		localparam longint T12  = ((T11 * TH2) >>> 30) / 600;
		localparam longint SUM  = TH - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10 -
			T11 + T12;
		localparam longint SUMC = (SUM < 0) ? longint'(0) : SUM;
		localparam longint RQ   = (SUMC + (longint'(1) <<< (29 - TRIG_FRACTION_BITS))) >>>
			(30 - TRIG_FRACTION_BITS);
		localparam longint ONE_Q = longint'(1) <<< TRIG_FRACTION_BITS;
		assign sin_tab[g] = TMW'((RQ > ONE_Q) ? ONE_Q : RQ);
	end

	logic [spc_pkg::KIND_W-1:0]       kind_q;
	logic signed [spc_pkg::POS_W-1:0] shape_x_q;
	logic signed [spc_pkg::POS_W-1:0] shape_y_q;
	logic [spc_pkg::SIZE_W-1:0]       size_x_q;
	logic [spc_pkg::SIZE_W-1:0]       size_y_q;
	logic [spc_pkg::SQ_W-1:0]         rx2_q;
	logic [spc_pkg::SQ_W-1:0]         ry2_q;
	logic [spc_pkg::RXRY_W-1:0]       rxry_q;
	logic [spc_pkg::COLOR_W-1:0]      fill_q;
	logic signed [TW-1:0]             cos_q;
	logic signed [TW-1:0]             sin_q;

	// fold the written angle into 0..359 and pick the quadrant
	logic [spc_pkg::TILT_W-1:0] deg;
	logic [6:0]                 idx_s;
	logic [6:0]                 idx_c;
	logic                       neg_s;
	logic                       neg_c;
	logic [spc_pkg::SIZE_W-1:0] wr_size;
	logic signed [TW-1:0]       s_new;
	logic signed [TW-1:0]       c_new;

	always_comb begin
		deg = wr_data[spc_pkg::TILT_W-1] ?
			wr_data[spc_pkg::TILT_W-1:0] + spc_pkg::TILT_W'(360) :
			wr_data[spc_pkg::TILT_W-1:0];
		neg_s = 1'b0;
		neg_c = 1'b0;
		if (deg <= spc_pkg::TILT_W'(90)) begin
			idx_s = 7'(deg);
			idx_c = 7'(spc_pkg::TILT_W'(90) - deg);
		end else if (deg <= spc_pkg::TILT_W'(180)) begin
			idx_s = 7'(spc_pkg::TILT_W'(180) - deg);
			idx_c = 7'(deg - spc_pkg::TILT_W'(90));
			neg_c = 1'b1;
		end else if (deg <= spc_pkg::TILT_W'(270)) begin
			idx_s = 7'(deg - spc_pkg::TILT_W'(180));
			idx_c = 7'(spc_pkg::TILT_W'(270) - deg);
			neg_s = 1'b1;
			neg_c = 1'b1;
		end else begin
			idx_s = 7'(spc_pkg::TILT_W'(360) - deg);
			idx_c = 7'(deg - spc_pkg::TILT_W'(270));
			neg_s = 1'b1;
		end
		s_new = $signed({1'b0, sin_tab[idx_s]});
		c_new = $signed({1'b0, sin_tab[idx_c]});
		if (neg_s) begin
			s_new = -s_new;
		end
		if (neg_c) begin
			c_new = -c_new;
		end
		wr_size = wr_data[spc_pkg::SIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= spc_pkg::KIND_RECT;
			shape_x_q <= '0;
			shape_y_q <= '0;
			size_x_q  <= '0;
			size_y_q  <= '0;
			rx2_q     <= '0;
			ry2_q     <= '0;
			rxry_q    <= '0;
			fill_q    <= '0;
			cos_q     <= TW'(1) <<< TRIG_FRACTION_BITS;
			sin_q     <= '0;
		end else begin
			rxry_q <= spc_pkg::RXRY_W'(rx2_q) * spc_pkg::RXRY_W'(ry2_q);
			if (wr_en) begin
				unique case (wr_index)
					spc_pkg::REG_SHAPE_KIND: kind_q <= wr_data[spc_pkg::KIND_W-1:0];
					spc_pkg::REG_SHAPE_X: shape_x_q <= $signed(wr_data[spc_pkg::POS_W-1:0]);
					spc_pkg::REG_SHAPE_Y: shape_y_q <= $signed(wr_data[spc_pkg::POS_W-1:0]);
					spc_pkg::REG_SIZE_X: begin
						size_x_q <= wr_size;
						rx2_q    <= spc_pkg::SQ_W'(wr_size) * spc_pkg::SQ_W'(wr_size);
					end
					spc_pkg::REG_SIZE_Y: begin
						size_y_q <= wr_size;
						ry2_q    <= spc_pkg::SQ_W'(wr_size) * spc_pkg::SQ_W'(wr_size);
					end
					spc_pkg::REG_TILT_DEG: begin
						cos_q <= c_new;
						sin_q <= s_new;
					end
					spc_pkg::REG_FILL_COLOR: fill_q <= wr_data[spc_pkg::COLOR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		cfg.kind    = kind_q;
		cfg.shape_x = shape_x_q;
		cfg.shape_y = shape_y_q;
		cfg.size_x  = size_x_q;
		cfg.size_y  = size_y_q;
		cfg.rx2     = rx2_q;
		cfg.ry2     = ry2_q;
		cfg.rxry    = rxry_q;
		cfg.fill    = fill_q;
	end

	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

`default_nettype wire

// ----- rtl/spc_checker.sv -----
`default_nettype none

`include "shape_pixel_coverage_assert.svh"

module spc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          covered,
	input wire logic [spc_pkg::COLOR_W-1:0]   pixel_color
);

	// a miss always carries black
	`SPC_ASSERT_IMP(a_miss_black, clk, arst_n, out_valid && !covered, pixel_color == '0, "uncovered beat with nonzero color")

	// a held result beat keeps its payload
	`SPC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(covered) && $stable(pixel_color), "stalled result beat changed")

	// with the output draining, the pipeline never pushes back
	`SPC_ASSERT_IMP(a_no_backpressure, clk, arst_n, out_ready, in_ready, "input stalled while output is ready")

	// reset empties the pipeline
	`SPC_ASSERT_ALWAYS(a_reset_empty, clk, arst_n || !out_valid, "result beat during reset")

endmodule

bind shape_pixel_coverage spc_checker u_spc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (pixel.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.covered    (result.covered),
	.pixel_color(result.pixel_color)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spc_pkg::*;

	// pipeline depth of the block, pixel beat to result beat
	localparam int PIPE_LAT = 6;
	// cycles with no beat on either side before the run is called hung
	localparam int IDLE_LIMIT = 2000;
	// random pixel beats after the directed part
	localparam int RANDOM_PIXELS = 1050;
	localparam int FRAC = TRIG_FRAC_DEF;

	typedef struct {
		bit                 covered;
		logic [COLOR_W-1:0] color;
	} cover_result_t;

	// predicts coverage per pixel and checks result beats in order
	class coverage_tracker;
		logic [KIND_W-1:0]  kind;
		int                 org_x;
		int                 org_y;
		int                 rad_x;
		int                 rad_y;
		int                 tilt;
		logic [COLOR_W-1:0] fill;
		longint             sine_q[91];
		cover_result_t      expected_cover[$];
		int                 errors;
		int                 checked;
		int                 hits;

		function new();
			longint th;
			longint th2;
			longint term;
			longint acc;
			longint r;
			kind = KIND_RECT;
			org_x = 0;
			org_y = 0;
			rad_x = 0;
			rad_y = 0;
			tilt = 0;
			fill = '0;
			errors = 0;
			checked = 0;
			hits = 0;
			// whole-degree sine table, taylor series in q30 then rounded
			for (int a = 0; a <= 90; a++) begin
				th = (longint'(a) * PI_Q30) / 180;
				th2 = (th * th) >> 30;
				term = th;
				acc = th;
				for (int k = 1; k <= 12; k++) begin
					if (term != 0) begin
						term = ((term * th2) >> 30) / longint'((2 * k) * (2 * k + 1));
						if (k % 2 == 1) begin
							acc = acc - term;
						end else begin
							acc = acc + term;
						end
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				r = (acc + (longint'(1) << (29 - FRAC))) >> (30 - FRAC);
				if (r > (longint'(1) << FRAC)) begin
					r = longint'(1) << FRAC;
				end
				sine_q[a] = r;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SHAPE_KIND: kind = data[KIND_W-1:0];
				REG_SHAPE_X:    org_x = int'($signed(data[POS_W-1:0]));
				REG_SHAPE_Y:    org_y = int'($signed(data[POS_W-1:0]));
				REG_SIZE_X:     rad_x = int'(data[SIZE_W-1:0]);
				REG_SIZE_Y:     rad_y = int'(data[SIZE_W-1:0]);
				REG_TILT_DEG:   tilt = int'($signed(data[TILT_W-1:0]));
				REG_FILL_COLOR: fill = data[COLOR_W-1:0];
				default: ;
			endcase
		endfunction

		// magnitude of a q(frac) value rounded half up to q8
		function longint q8_mag(longint v);
			longint m;
			int sh;
			m = (v < 0) ? -v : v;
			sh = FRAC - ROT_FRAC;
			if (sh == 0) begin
				return m;
			end
			return (m + (longint'(1) << (sh - 1))) >> sh;
		endfunction

		function bit inside_tilted(longint ox, longint oy);
			longint reach;
			longint c;
			longint s;
			longint u;
			longint v;
			longint rx2;
			longint ry2;
			int d;
			reach = rad_x + rad_y + 2;
			if (ox > reach || ox < -reach || oy > reach || oy < -reach) begin
				return 1'b0;
			end
			// any tilt folds into 0..359
			d = tilt % 360;
			if (d < 0) begin
				d = d + 360;
			end
			if (d <= 90) begin
				s = sine_q[d];
				c = sine_q[90 - d];
			end else if (d <= 180) begin
				s = sine_q[180 - d];
				c = -sine_q[d - 90];
			end else if (d <= 270) begin
				s = -sine_q[d - 180];
				c = -sine_q[270 - d];
			end else begin
				s = -sine_q[360 - d];
				c = sine_q[d - 270];
			end
			u = q8_mag(ox * c + oy * s);
			v = q8_mag(-ox * s + oy * c);
			rx2 = longint'(rad_x) * rad_x;
			ry2 = longint'(rad_y) * rad_y;
			return (u * u * ry2 + v * v * rx2) <= ((rx2 * ry2) << (2 * ROT_FRAC));
		endfunction

		function bit pixel_inside(int x, int y);
			longint ox;
			longint oy;
			longint rx2;
			longint ry2;
			ox = longint'(x) - org_x;
			oy = longint'(y) - org_y;
			rx2 = longint'(rad_x) * rad_x;
			ry2 = longint'(rad_y) * rad_y;
			if (x >= CANVAS_WIDTH_DEF || y >= CANVAS_HEIGHT_DEF) begin
				return 1'b0;
			end
			case (kind)
				KIND_RECT: return ox >= 0 && ox < rad_x && oy >= 0 && oy < rad_y;
				KIND_ELLIPSE: begin
					if (rad_x == 0 || rad_y == 0) begin
						return 1'b0;
					end
					return (ox * ox * ry2 + oy * oy * rx2) <= rx2 * ry2;
				end
				KIND_ROTATED: begin
					if (rad_x == 0 || rad_y == 0) begin
						return 1'b0;
					end
					return inside_tilted(ox, oy);
				end
				default: return 1'b0;
			endcase
		endfunction

		function void note_pixel(int x, int y);
			cover_result_t e;
			e.covered = pixel_inside(x, y);
			e.color = e.covered ? fill : '0;
			expected_cover.push_back(e);
		endfunction

		function void check_result(logic cov, logic [COLOR_W-1:0] color);
			cover_result_t e;
			if (expected_cover.size() == 0) begin
				$display("%0t: result beat with no pixel pending, covered %b color %06h",
					$time, cov, color);
				errors++;
				return;
			end
			e = expected_cover.pop_front();
			checked++;
			if (e.covered) begin
				hits++;
			end
			if (cov !== e.covered) begin
				$display("%0t: covered mismatch, expected %b actual %b",
					$time, e.covered, cov);
				errors++;
			end
			if (color !== e.color) begin
				$display("%0t: pixel_color mismatch, expected %06h actual %06h",
					$time, e.color, color);
				errors++;
			end
		endfunction

		function int pending();
			return expected_cover.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	spc_in_if  pix_if();
	spc_out_if res_if();

	shape_pixel_coverage uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pix_if),
		.result   (res_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	coverage_tracker tracker;
	int burst_left;
	int shapes_loaded;
	int kind_loads[4];
	int random_sent;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// write one shape register, strobe held for a single edge
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// drop valid and let every pending pixel come out of the pipe
	task drain_pipe();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// load a whole shape while the block is idle
	task load_shape(input int kind, input int sx, input int sy, input int rx,
			input int ry, input int tilt, input int color);
		drain_pipe();
		write_reg(REG_SHAPE_KIND, CFG_DATA_W'(kind));
		write_reg(REG_SHAPE_X, CFG_DATA_W'(sx));
		write_reg(REG_SHAPE_Y, CFG_DATA_W'(sy));
		write_reg(REG_SIZE_X, CFG_DATA_W'(rx));
		write_reg(REG_SIZE_Y, CFG_DATA_W'(ry));
		write_reg(REG_TILT_DEG, CFG_DATA_W'(tilt));
		write_reg(REG_FILL_COLOR, CFG_DATA_W'(color));
		shapes_loaded++;
		kind_loads[kind & 3]++;
	endtask

	// one pixel beat; the sender runs in bursts with random gaps between them
	task send_pixel(input int x, input int y);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				pix_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		pix_if.valid <= 1'b1;
		pix_if.pixel_x <= COORD_W'(x);
		pix_if.pixel_y <= COORD_W'(y);
		do begin
			@(posedge clk);
		end while (pix_if.ready !== 1'b1);
		tracker.note_pixel(x, y);
	endtask

	// coordinate near a centre, wrapped onto the canvas
	function automatic int near_coord(int centre, int span);
		return (centre + int'($urandom_range(0, 2 * span)) - span) & (CANVAS_WIDTH_DEF - 1);
	endfunction

	// pixels mostly land around the current shape so edges get hit often
	task random_pixel();
		int cx;
		int cy;
		int span;
		if ($urandom_range(0, 3) == 0) begin
			send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
		end else begin
			if (tracker.kind == KIND_RECT) begin
				cx = tracker.org_x + tracker.rad_x / 2;
				cy = tracker.org_y + tracker.rad_y / 2;
				span = (tracker.rad_x > tracker.rad_y ? tracker.rad_x : tracker.rad_y) / 2 + 3;
			end else begin
				cx = tracker.org_x;
				cy = tracker.org_y;
				span = (tracker.rad_x > tracker.rad_y ? tracker.rad_x : tracker.rad_y) + 3;
			end
			send_pixel(near_coord(cx, span), near_coord(cy, span));
		end
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 0;
		end else if (r == 1) begin
			return $urandom_range(300, 1023);
		end
		return $urandom_range(1, 120);
	endfunction

	function automatic int pick_pos();
		if ($urandom_range(0, 7) == 0) begin
			return int'($urandom_range(0, 4095)) - 2048;
		end
		return int'($urandom_range(0, 1100)) - 40;
	endfunction

	// receiver: full-rate stretches, random ready, and long stalls
	initial begin
		int mode;
		int mode_left;
		int stall_left;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= ($urandom_range(0, 9) < 7);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						res_if.ready <= 1'b0;
					end else begin
						res_if.ready <= 1'b1;
						if ($urandom_range(0, 3) == 0) begin
							stall_left = $urandom_range(1, 12);
						end
					end
				end
			endcase
		end
	end

	// result beats go to the tracker in arrival order
	always @(posedge clk) begin
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			tracker.check_result(res_if.covered, res_if.pixel_color);
		end
	end

	// watchdog on cycles with no beat at all
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_if.valid === 1'b1 && pix_if.ready === 1'b1) ||
					(res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		int n;
		int r;
		int kind;
		tracker = new();
		burst_left = 0;
		shapes_loaded = 0;
		random_sent = 0;
		foreach (kind_loads[i]) begin
			kind_loads[i] = 0;
		end
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		pix_if.valid = 1'b0;
		pix_if.pixel_x = '0;
		pix_if.pixel_y = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset shape is an empty rectangle, nothing is covered
		send_pixel(0, 0);
		send_pixel(1023, 1023);

		// small rectangle, corners inside and one step past each edge
		load_shape(KIND_RECT, 10, 20, 5, 3, 0, 24'hFF0000);
		send_pixel(10, 20);
		send_pixel(14, 22);
		send_pixel(15, 22);
		send_pixel(9, 20);
		send_pixel(14, 23);

		// rectangle at full size, far corners of the canvas
		load_shape(KIND_RECT, 0, 0, 1023, 1023, 0, 24'hFFFFFF);
		send_pixel(1022, 1022);
		send_pixel(1023, 5);

		// axis ellipse, points exactly on and just past both radii
		load_shape(KIND_ELLIPSE, 512, 512, 100, 50, 0, 24'h00FF00);
		send_pixel(612, 512);
		send_pixel(613, 512);
		send_pixel(512, 562);
		send_pixel(512, 563);
		send_pixel(512, 512);

		// zero radius draws nothing, even at the centre
		load_shape(KIND_ELLIPSE, 512, 512, 0, 50, 0, 24'h123456);
		send_pixel(512, 512);

		// centre at the extremes of the position range, largest radii
		load_shape(KIND_ELLIPSE, 2047, -2048, 1023, 1023, 0, 24'h0000FF);
		send_pixel(1023, 0);

		// quarter turn swaps the long axis onto y
		load_shape(KIND_ROTATED, 500, 500, 100, 20, 90, 24'hABCDEF);
		send_pixel(500, 600);
		send_pixel(600, 500);
		send_pixel(500, 500);

		// tilt below -180 folds back into one turn
		load_shape(KIND_ROTATED, 500, 500, 80, 30, -256, 24'h00FFFF);
		send_pixel(500, 500);
		send_pixel(560, 560);

		// largest tilt, thin ellipse
		load_shape(KIND_ROTATED, 500, 500, 1023, 1, 255, 24'hFF00FF);
		send_pixel(500, 500);

		// unused shape kind covers nothing
		load_shape(3, 500, 500, 100, 100, 0, 24'hFFFFFF);
		send_pixel(500, 500);

		// rotated ellipse with a zero radius
		load_shape(KIND_ROTATED, 500, 500, 100, 0, 45, 24'h000000);
		send_pixel(500, 500);

		// random shapes, each followed by a run of pixels mostly around it
		while (random_sent < RANDOM_PIXELS) begin
			r = $urandom_range(0, 15);
			if (r < 5) begin
				kind = KIND_RECT;
			end else if (r < 10) begin
				kind = KIND_ELLIPSE;
			end else if (r < 15) begin
				kind = KIND_ROTATED;
			end else begin
				kind = 3;
			end
			load_shape(kind, pick_pos(), pick_pos(), pick_size(), pick_size(),
				int'($urandom_range(0, 511)) - 256, $urandom_range(0, 24'hFFFFFF));
			n = $urandom_range(20, 60);
			for (int i = 0; i < n; i++) begin
				random_pixel();
				random_sent++;
			end
		end

		drain_pipe();
		$display("summary: %0d pixels checked, %0d covered, over %0d shape loads",
			tracker.checked, tracker.hits, shapes_loaded);
		$display("summary: loads by kind rect %0d ellipse %0d rotated %0d unused %0d",
			kind_loads[0], kind_loads[1], kind_loads[2], kind_loads[3]);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
